@@ rtl/pers_pkg.sv @@
package pers_pkg;

  localparam int unsigned QW = 20;

  localparam logic signed [QW-1:0] GravityReset = 20'sd52429;
  localparam logic signed [QW-1:0] YLimit       = 20'sd68812;
  localparam logic signed [QW-1:0] SpawnY       = 20'sd58982;
  localparam logic signed [QW-1:0] SpawnVyBase  = -20'sd19661;
  localparam logic signed [QW-1:0] SpawnPxBias  = 20'sd6554;
  localparam logic [QW-1:0]        SpawnLife    = 20'd32768;
  localparam logic [QW-1:0]        PxNumAdd     = 20'd9;
  localparam logic [QW-1:0]        RedNumAdd    = 20'd524293;
  localparam logic [QW-1:0]        GreenNumAdd  = 20'd196613;
  localparam logic [31:0]          SeedMul      = 32'd2654435761;
  localparam logic [31:0]          SeedAdd      = 32'd9999991;
  localparam logic [36:0]          HalfQ16      = 37'd32768;

  // floor(x / 10) = (x * Div10Mul) >> Div10Shift for x below 699050
  localparam int unsigned          Div10Shift   = 22;
  localparam logic [18:0]          Div10Mul     = 19'd419431;

  typedef logic signed [QW-1:0] q_t;
  typedef logic [14:0] rnd15_t;
  typedef logic [38:0] div_prod_t;

  typedef struct packed {
    q_t          pos_x;
    q_t          pos_y;
    q_t          vel_x;
    q_t          vel_y;
    q_t          life_left;
    q_t          colour_red;
    q_t          colour_green;
    logic [15:0] particle_index;
    logic [15:0] time_step;
  } in_item_t;

  typedef struct packed {
    q_t   new_pos_x;
    q_t   new_pos_y;
    q_t   new_vel_x;
    q_t   new_vel_y;
    q_t   new_life;
    q_t   new_red;
    q_t   new_green;
    logic respawned;
  } out_item_t;

  function automatic q_t sat22(input logic signed [21:0] v);
    q_t r;
    if (v > 22'sd524287) begin
      r = 20'sd524287;
    end else if (v < -22'sd524288) begin
      r = -20'sd524288;
    end else begin
      r = v[19:0];
    end
    return r;
  endfunction

  // round a q.32 product to q.16, halves toward +inf
  function automatic logic signed [20:0] rnd_q16(input logic signed [36:0] p);
    logic signed [36:0] t;
    t = p + $signed(HalfQ16);
    return t[36:16];
  endfunction

  function automatic logic [31:0] xs_next(input logic [31:0] r);
    logic [31:0] a;
    logic [31:0] b;
    a = r ^ (r << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

endpackage

@@ rtl/pers_if.sv @@
interface pers_in_if;
  logic               valid;
  logic               ready;
  pers_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pers_out_if;
  logic                valid;
  logic                ready;
  pers_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pers_cfg_if;
  logic          valid;
  logic          ready;
  pers_pkg::q_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/particle_euler_respawn_step_unit.sv @@
// Euler step of one particle per transaction, with respawn from a xorshift32
// generator seeded by the particle index.
// in_if carries one particle (position, velocity, life, red, green, index,
// time step); out_if returns one updated particle per input transaction,
// in order, with a respawned flag. cfg_if writes the gravity register
// (signed Q4.16); it is always ready and should be written while idle.
// The datapath is a five stage pipeline: products, velocity, x and life update
// with the first generator rounds, the y product with the last rounds,
// the y update with the respawn reciprocal products, and the output register.
// Throughput is one transaction per cycle; each stage holds when the stage
// after it is full and stalled, so a stall on out_if backs up through the
// pipeline and drops in_if.ready only once every stage holds an item.
// Nothing is lost or repeated across a stall.
// Reset clears all stage valid bits and sets gravity to 52429 (about 0.8).
module particle_euler_respawn_step_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  pers_in_if.sink    in_if,
  pers_out_if.source out_if,
  pers_cfg_if.sink   cfg_if
);

  pers_pkg::q_t gravity_q;

  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, out_v_q;
  logic adv1, adv2, adv3, adv4, adv5;

  assign adv5 = !out_v_q || out_if.ready;
  assign adv4 = !s4_v_q || adv5;
  assign adv3 = !s3_v_q || adv4;
  assign adv2 = !s2_v_q || adv3;
  assign adv1 = !s1_v_q || adv2;

  assign in_if.ready  = adv1;
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gravity_q <= pers_pkg::GravityReset;
    end else if (cfg_if.valid) begin
      gravity_q <= cfg_if.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (adv1) s1_v_q  <= in_if.valid;
      if (adv2) s2_v_q  <= s1_v_q;
      if (adv3) s3_v_q  <= s2_v_q;
      if (adv4) s4_v_q  <= s3_v_q;
      if (adv5) out_v_q <= s4_v_q;
    end
  end

  // stage 1: products and seed
  logic signed [16:0] dt_in;
  logic signed [36:0] gdt_d, vxdt_d;
  logic [31:0]        seed_d;

  assign dt_in  = $signed({1'b0, in_if.data.time_step});
  assign gdt_d  = gravity_q * dt_in;
  assign vxdt_d = in_if.data.vel_x * dt_in;
  assign seed_d = 32'({16'd0, in_if.data.particle_index} * pers_pkg::SeedMul);

  logic signed [36:0] s1_gdt_q, s1_vxdt_q;
  logic [31:0]        s1_seed_q;
  pers_pkg::q_t       s1_px_q, s1_py_q, s1_vx_q, s1_vy_q, s1_life_q, s1_red_q, s1_green_q;
  logic [15:0]        s1_dt_q;

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      s1_gdt_q   <= gdt_d;
      s1_vxdt_q  <= vxdt_d;
      s1_seed_q  <= seed_d;
      s1_px_q    <= in_if.data.pos_x;
      s1_py_q    <= in_if.data.pos_y;
      s1_vx_q    <= in_if.data.vel_x;
      s1_vy_q    <= in_if.data.vel_y;
      s1_life_q  <= in_if.data.life_left;
      s1_red_q   <= in_if.data.colour_red;
      s1_green_q <= in_if.data.colour_green;
      s1_dt_q    <= in_if.data.time_step;
    end
  end

  // stage 2: velocity, x and life update; generator rounds one and two
  logic signed [21:0] vy_sum, px_sum, life_sum;
  logic [31:0]        r1, r2;

  assign vy_sum   = 22'(s1_vy_q) + 22'(pers_pkg::rnd_q16(s1_gdt_q));
  assign px_sum   = 22'(s1_px_q) + 22'(pers_pkg::rnd_q16(s1_vxdt_q));
  assign life_sum = 22'(s1_life_q) - $signed({6'd0, s1_dt_q});
  assign r1       = pers_pkg::xs_next(s1_seed_q + pers_pkg::SeedAdd);
  assign r2       = pers_pkg::xs_next(r1);

  pers_pkg::q_t      s2_vy_q, s2_px_q, s2_life_q, s2_py_q, s2_vx_q, s2_red_q, s2_green_q;
  logic [15:0]       s2_dt_q;
  logic [31:0]       s2_r_q;
  pers_pkg::rnd15_t  s2_u0_q, s2_u1_q;

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      s2_vy_q    <= pers_pkg::sat22(vy_sum);
      s2_px_q    <= pers_pkg::sat22(px_sum);
      s2_life_q  <= pers_pkg::sat22(life_sum);
      s2_py_q    <= s1_py_q;
      s2_vx_q    <= s1_vx_q;
      s2_red_q   <= s1_red_q;
      s2_green_q <= s1_green_q;
      s2_dt_q    <= s1_dt_q;
      s2_r_q     <= r2;
      s2_u0_q    <= r1[14:0];
      s2_u1_q    <= r2[14:0];
    end
  end

  // stage 3: y product; generator rounds three to five
  logic signed [36:0] vydt_d;
  logic [31:0]        r3, r4, r5;

  assign vydt_d = s2_vy_q * $signed({1'b0, s2_dt_q});
  assign r3     = pers_pkg::xs_next(s2_r_q);
  assign r4     = pers_pkg::xs_next(r3);
  assign r5     = pers_pkg::xs_next(r4);

  logic signed [36:0] s3_vydt_q;
  pers_pkg::q_t       s3_vy_q, s3_px_q, s3_life_q, s3_py_q, s3_vx_q, s3_red_q, s3_green_q;
  pers_pkg::rnd15_t   s3_u0_q, s3_u1_q, s3_u2_q, s3_u3_q, s3_u4_q;

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      s3_vydt_q  <= vydt_d;
      s3_vy_q    <= s2_vy_q;
      s3_px_q    <= s2_px_q;
      s3_life_q  <= s2_life_q;
      s3_py_q    <= s2_py_q;
      s3_vx_q    <= s2_vx_q;
      s3_red_q   <= s2_red_q;
      s3_green_q <= s2_green_q;
      s3_u0_q    <= s2_u0_q;
      s3_u1_q    <= s2_u1_q;
      s3_u2_q    <= r3[14:0];
      s3_u3_q    <= r4[14:0];
      s3_u4_q    <= r5[14:0];
    end
  end

  // stage 4: y update, respawn decision, reciprocal products
  logic signed [21:0] py_sum;
  pers_pkg::q_t       py_new;
  logic               spawn_d;
  logic [19:0]        px_num, red_num, green_num;

  assign py_sum    = 22'(s3_py_q) + 22'(pers_pkg::rnd_q16(s3_vydt_q));
  assign py_new    = pers_pkg::sat22(py_sum);
  assign spawn_d   = (s3_life_q <= 20'sd0) || (py_new > pers_pkg::YLimit);
  assign px_num    = {3'd0, s3_u0_q, 2'b00} + pers_pkg::PxNumAdd;
  assign red_num   = {3'd0, s3_u3_q, 2'b00} + pers_pkg::RedNumAdd;
  assign green_num = 20'({5'd0, s3_u4_q} * 20'd6) + pers_pkg::GreenNumAdd;

  pers_pkg::div_prod_t s4_px_prod_q, s4_red_prod_q, s4_green_prod_q;
  pers_pkg::q_t        s4_px_q, s4_py_q, s4_vx_q, s4_vy_q, s4_life_q, s4_red_q, s4_green_q;
  pers_pkg::q_t        s4_vx_sp_q, s4_vy_sp_q, s4_life_sp_q;
  logic                s4_spawn_q;

  always_ff @(posedge clk_i) begin
    if (adv4) begin
      s4_px_prod_q    <= 39'(px_num) * 39'(pers_pkg::Div10Mul);
      s4_red_prod_q   <= 39'(red_num) * 39'(pers_pkg::Div10Mul);
      s4_green_prod_q <= 39'(green_num) * 39'(pers_pkg::Div10Mul);
      s4_px_q         <= s3_px_q;
      s4_py_q         <= py_new;
      s4_vx_q         <= s3_vx_q;
      s4_vy_q         <= s3_vy_q;
      s4_life_q       <= s3_life_q;
      s4_red_q        <= s3_red_q;
      s4_green_q      <= s3_green_q;
      s4_vx_sp_q      <= $signed({5'd0, s3_u1_q}) - 20'sd16384;
      s4_vy_sp_q      <= pers_pkg::SpawnVyBase - $signed({5'd0, s3_u2_q});
      s4_life_sp_q    <= $signed(pers_pkg::SpawnLife + 20'({5'd0, s3_u2_q} * 20'd3));
      s4_spawn_q      <= spawn_d;
    end
  end

  // stage 5: quotient extraction and selection into the output register
  localparam int unsigned QLo = pers_pkg::Div10Shift;
  pers_pkg::q_t        px_sp, red_sp, green_sp;
  pers_pkg::out_item_t out_d, out_q;

  assign px_sp    = $signed({3'd0, s4_px_prod_q[38:QLo]}) - pers_pkg::SpawnPxBias;
  assign red_sp   = $signed({3'd0, s4_red_prod_q[38:QLo]});
  assign green_sp = $signed({3'd0, s4_green_prod_q[38:QLo]});

  always_comb begin
    if (s4_spawn_q) begin
      out_d.new_pos_x = px_sp;
      out_d.new_pos_y = pers_pkg::SpawnY;
      out_d.new_vel_x = s4_vx_sp_q;
      out_d.new_vel_y = s4_vy_sp_q;
      out_d.new_life  = s4_life_sp_q;
      out_d.new_red   = red_sp;
      out_d.new_green = green_sp;
    end else begin
      out_d.new_pos_x = s4_px_q;
      out_d.new_pos_y = s4_py_q;
      out_d.new_vel_x = s4_vx_q;
      out_d.new_vel_y = s4_vy_q;
      out_d.new_life  = s4_life_q;
      out_d.new_red   = s4_red_q;
      out_d.new_green = s4_green_q;
    end
    out_d.respawned = s4_spawn_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv5) begin
      out_q <= out_d;
    end
  end

  assign out_if.valid = out_v_q;
  assign out_if.data  = out_q;

  a_spawn_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.data.respawned |-> out_if.data.new_pos_y == pers_pkg::SpawnY)
    else $error("respawned particle has wrong y");

  a_spawn_life: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.data.respawned |-> out_if.data.new_life >= 20'sd32768)
    else $error("respawned particle has short life");

  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_if.valid |-> in_if.ready)
    else $error("input stalled with empty output register");

  a_spawn_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.data.respawned |->
      (out_if.data.new_pos_x >= -20'sd6554) && (out_if.data.new_pos_x <= 20'sd6553))
    else $error("respawned x out of range");

endmodule

@@ verif/particle_euler_respawn_step_unit_test.sv @@
module particle_euler_respawn_step_unit_test;

  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned ReportLimit = 10;
  localparam logic signed [19:0] GravityAtReset = 20'sd52429;
  localparam longint YCeiling = 68812;
  localparam longint RespawnY = 58982;
  localparam logic [31:0] IndexMul = 32'd2654435761;
  localparam logic [31:0] IndexAdd = 32'd9999991;
  localparam longint QHigh = 524287;
  localparam longint QLow = -524288;

  class particle_tracker;
    pers_pkg::q_t gravity;
    pers_pkg::out_item_t expected_particles[$];
    int unsigned failures;

    function new();
      gravity = GravityAtReset;
      failures = 0;
    endfunction

    function automatic longint clamp_q(longint v);
      if (v > QHigh) begin
        return QHigh;
      end else if (v < QLow) begin
        return QLow;
      end
      return v;
    endfunction

    function automatic longint round_q16(longint p);
      return (p + 32768) >>> 16;
    endfunction

    function automatic longint floor_div(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) begin
        q = q - 1;
      end
      return q;
    endfunction

    function automatic longint div_nearest(longint num, longint den);
      return floor_div(2 * num + den, 2 * den);
    endfunction

    function automatic pers_pkg::out_item_t advance_particle(pers_pkg::in_item_t p);
      longint g, dt, px, py, vx, vy, life, red, green;
      longint u[5];
      logic [31:0] r;
      pers_pkg::out_item_t o;
      g = gravity;
      dt = p.time_step;
      px = p.pos_x;
      py = p.pos_y;
      vx = p.vel_x;
      vy = p.vel_y;
      life = p.life_left;
      red = p.colour_red;
      green = p.colour_green;
      o.respawned = 1'b0;

      vy = clamp_q(vy + round_q16(g * dt));
      px = clamp_q(px + round_q16(vx * dt));
      py = clamp_q(py + round_q16(vy * dt));
      life = clamp_q(life - dt);

      if (life <= 0 || py > YCeiling) begin
        r = 32'(p.particle_index) * IndexMul + IndexAdd;
        for (int k = 0; k < 5; k++) begin
          r = r ^ (r << 13);
          r = r ^ (r >> 17);
          r = r ^ (r << 5);
          u[k] = r[14:0];
        end
        px = div_nearest((u[0] - 16384) * 2, 5);
        py = RespawnY;
        vx = u[1] - 16384;
        vy = div_nearest(-(196608 + 10 * u[2]), 10);
        red = div_nearest(262144 + 2 * u[3], 5);
        green = div_nearest(98304 + 3 * u[4], 5);
        life = 32768 + 3 * u[2];
        o.respawned = 1'b1;
      end

      o.new_pos_x = px[19:0];
      o.new_pos_y = py[19:0];
      o.new_vel_x = vx[19:0];
      o.new_vel_y = vy[19:0];
      o.new_life = life[19:0];
      o.new_red = red[19:0];
      o.new_green = green[19:0];
      return o;
    endfunction

    function void note_particle(pers_pkg::in_item_t p);
      expected_particles.push_back(advance_particle(p));
    endfunction

    function void flag(string what, longint want, longint got);
      failures++;
      if (failures <= ReportLimit) begin
        $display("mismatch on %s: expected %0d, got %0d", what, want, got);
      end
    endfunction

    function void check_particle(pers_pkg::out_item_t got);
      pers_pkg::out_item_t want;
      if (expected_particles.size() == 0) begin
        failures++;
        if (failures <= ReportLimit) begin
          $display("unexpected result transaction: %h", got);
        end
        return;
      end
      want = expected_particles.pop_front();
      if (got.new_pos_x !== want.new_pos_x) flag("new_pos_x", want.new_pos_x, got.new_pos_x);
      if (got.new_pos_y !== want.new_pos_y) flag("new_pos_y", want.new_pos_y, got.new_pos_y);
      if (got.new_vel_x !== want.new_vel_x) flag("new_vel_x", want.new_vel_x, got.new_vel_x);
      if (got.new_vel_y !== want.new_vel_y) flag("new_vel_y", want.new_vel_y, got.new_vel_y);
      if (got.new_life !== want.new_life) flag("new_life", want.new_life, got.new_life);
      if (got.new_red !== want.new_red) flag("new_red", want.new_red, got.new_red);
      if (got.new_green !== want.new_green) flag("new_green", want.new_green, got.new_green);
      if (got.respawned !== want.respawned) flag("respawned", want.respawned, got.respawned);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  int unsigned in_idle_pct;
  int unsigned out_stall_pct;
  int unsigned quiet_cycles;
  particle_tracker tracker = new();

  pers_in_if in_ch ();
  pers_out_if out_ch ();
  pers_cfg_if cfg_ch ();

  particle_euler_respawn_step_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // accepted transactions and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_ch.valid && cfg_ch.ready) tracker.gravity = cfg_ch.data;
      if (in_ch.valid && in_ch.ready) tracker.note_particle(in_ch.data);
      if (out_ch.valid && out_ch.ready) tracker.check_particle(out_ch.data);
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
  end

  function automatic pers_pkg::q_t rand_q(int lo, int hi);
    return pers_pkg::q_t'(lo + int'($urandom_range(hi - lo)));
  endfunction

  function automatic pers_pkg::in_item_t make_particle(int px, int py, int vx, int vy,
                                                       int life, int red, int green,
                                                       int idx, int dt);
    pers_pkg::in_item_t p;
    p.pos_x = pers_pkg::q_t'(px);
    p.pos_y = pers_pkg::q_t'(py);
    p.vel_x = pers_pkg::q_t'(vx);
    p.vel_y = pers_pkg::q_t'(vy);
    p.life_left = pers_pkg::q_t'(life);
    p.colour_red = pers_pkg::q_t'(red);
    p.colour_green = pers_pkg::q_t'(green);
    p.particle_index = 16'(idx);
    p.time_step = 16'(dt);
    return p;
  endfunction

  function automatic pers_pkg::in_item_t random_particle();
    pers_pkg::in_item_t p;
    if ($urandom_range(99) < 75) begin
      // plausible particle state around the visible region
      p.pos_x = rand_q(-131072, 131072);
      p.pos_y = rand_q(-131072, 78643);
      p.vel_x = rand_q(-98304, 98304);
      p.vel_y = rand_q(-131072, 131072);
      p.life_left = ($urandom_range(3) == 0) ? rand_q(-2000, 6000) : rand_q(0, 131072);
      p.colour_red = rand_q(0, 65536);
      p.colour_green = rand_q(0, 65536);
      p.particle_index = 16'($urandom);
      p.time_step = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(4000));
    end else begin
      p.pos_x = pers_pkg::q_t'($urandom);
      p.pos_y = pers_pkg::q_t'($urandom);
      p.vel_x = pers_pkg::q_t'($urandom);
      p.vel_y = pers_pkg::q_t'($urandom);
      p.life_left = pers_pkg::q_t'($urandom);
      p.colour_red = pers_pkg::q_t'($urandom);
      p.colour_green = pers_pkg::q_t'($urandom);
      p.particle_index = 16'($urandom);
      p.time_step = 16'($urandom);
    end
    return p;
  endfunction

  // called and returns at a falling edge
  task automatic send_particle(pers_pkg::in_item_t p);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= p;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (tracker.expected_particles.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic set_gravity(pers_pkg::q_t g);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= g;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_phase(int unsigned idle, int unsigned stall, pers_pkg::q_t g,
                           int unsigned count);
    set_gravity(g);
    in_idle_pct = idle;
    out_stall_pct = stall;
    repeat (count) send_particle(random_particle());
    in_ch.valid <= 1'b0;
  endtask

  initial begin
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    in_idle_pct = 0;
    out_stall_pct = 0;
    quiet_cycles = 0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed cases at reset gravity
    send_particle(make_particle(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_particle(make_particle(0, 0, 65536, 0, 65536, 32768, 32768, 1, 1092));
    send_particle(make_particle(524287, 524287, 524287, 524287, 524287, 524287, 524287,
                                65535, 65535));
    send_particle(make_particle(-524288, -524288, -524288, -524288, -524288, -524288,
                                -524288, 65535, 65535));
    send_particle(make_particle(524287, -524288, 524287, -524288, 524287, 1, 2, 7, 65535));
    send_particle(make_particle(-524288, 0, -524288, 0, 524287, 3, 4, 8, 65535));
    // y at the ceiling stays, one above respawns
    send_particle(make_particle(100, 68812, 0, 0, 65536, 5, 6, 9, 0));
    send_particle(make_particle(100, 68813, 0, 0, 65536, 5, 6, 10, 0));
    // life reaching exactly zero respawns, one above does not
    send_particle(make_particle(0, 0, 0, 0, 1000, 0, 0, 11, 1000));
    send_particle(make_particle(0, 0, 0, 0, 1001, 0, 0, 12, 1000));
    // rounding of exact halves
    send_particle(make_particle(0, 0, 1, 0, 65536, 0, 0, 13, 32768));
    send_particle(make_particle(0, 0, -1, 0, 65536, 0, 0, 14, 32768));
    send_particle(make_particle(0, 0, 3, 0, 65536, 0, 0, 15, 32768));
    send_particle(make_particle(0, 0, -3, 0, 65536, 0, 0, 16, 32768));
    // vertical velocity saturating from gravity
    send_particle(make_particle(0, -524288, 0, 524287, 524287, 0, 0, 17, 65535));
    send_particle(make_particle(0, 0, 0, 0, -1, 0, 0, 12345, 0));
    send_particle(make_particle(0, 0, 0, 0, 65536, 0, 0, 54321, 65535));
    send_particle(make_particle(1, 2, 3, 4, 65535, 6, 7, 32768, 65535));
    in_ch.valid <= 1'b0;

    run_phase(0, 0, pers_pkg::q_t'(QLow), 190);
    run_phase(69, 0, pers_pkg::q_t'(QHigh), 190);
    run_phase(0, 69, '0, 190);
    run_phase(19, 19, rand_q(-524288, 524287), 190);
    run_phase(0, 0, rand_q(-131072, 131072), 190);

    wait_drained();
    if (tracker.failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
